// ----- hw/rtl/same_popcount_mask_enumerator_macros.svh -----
// ----------------------------------------------------------------------------
// same_popcount_mask_enumerator_macros
// Assertion macros used by the checker of the mask enumerator.
// ----------------------------------------------------------------------------
`ifndef SAME_POPCOUNT_MASK_ENUMERATOR_MACROS_SVH
`define SAME_POPCOUNT_MASK_ENUMERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SPME_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/spme_pkg.sv -----
// ----------------------------------------------------------------------------
// spme_pkg
// Types and constants of the same-popcount mask enumerator.
// ----------------------------------------------------------------------------
package spme_pkg;

    localparam int SKIP_W     = 6;
    localparam int MAXB_W     = 5;
    localparam int STRIDE_W   = 7;
    localparam int OFFS_W     = 6;
    localparam int STEP_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int IN_TDATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SKIP_LOW_BITS = 2'd0,
        REG_MAX_MASK_BITS = 2'd1,
        REG_STRIDE        = 2'd2,
        REG_FIRST_OFFSET  = 2'd3
    } cfg_reg_t;

    localparam logic [SKIP_W-1:0]   SKIP_RST   = 6'd6;
    localparam logic [MAXB_W-1:0]   MAXB_RST   = 5'd8;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 7'd1;
    localparam logic [OFFS_W-1:0]   OFFS_RST   = 6'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_SUM,
        ST_CHECK,
        ST_RIPPLE,
        ST_FILL,
        ST_ADVANCE,
        ST_STORE
    } state_t;

    typedef struct packed {
        logic load;
        logic use_start;
        logic count;
        logic sum;
        logic ripple;
        logic fill;
        logic advance;
        logic store;
        logic zero;
    } dp_cmd_t;

    typedef struct packed {
        logic x_zero;
        logic no_usable;
    } dp_sts_t;

endpackage

// ----- hw/rtl/spme_ctrl.sv -----
// ----------------------------------------------------------------------------
// spme_ctrl
// Sequencer of the mask enumerator: request handshake, step count,
// started / exhausted flags and the output valid register.
// ----------------------------------------------------------------------------
module spme_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            restart,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_done,
    input  logic [spme_pkg::OFFS_W-1:0]     first_offset,
    input  logic [spme_pkg::STRIDE_W-1:0]   stride,
    output spme_pkg::dp_cmd_t               cmd,
    input  spme_pkg::dp_sts_t               sts
);

    spme_pkg::state_t               state_reg, state_next;
    logic                           started_reg, started_next;
    logic                           exhausted_reg, exhausted_next;
    logic                           use_start_reg, use_start_next;
    logic                           zero_reg, zero_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic                           done_reg, done_next;
    logic [spme_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic                           started_eff;
    logic                           exhausted_eff;
    logic                           out_free;
    logic                           result_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spme_pkg::ST_IDLE;
            started_reg   <= 1'b0;
            exhausted_reg <= 1'b0;
            use_start_reg <= 1'b0;
            zero_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            exhausted_reg <= exhausted_next;
            use_start_reg <= use_start_next;
            zero_reg      <= zero_next;
            m_tvalid_reg  <= m_tvalid_next;
            done_reg      <= done_next;
            cnt_reg       <= cnt_next;
        end
    end

    assign out_free    = !m_tvalid_reg || m_tready;
    assign result_zero = zero_reg || sts.x_zero;

    always_comb begin
        state_next     = state_reg;
        started_next   = started_reg;
        exhausted_next = exhausted_reg;
        use_start_next = use_start_reg;
        zero_next      = zero_reg;
        done_next      = done_reg;
        cnt_next       = cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        cmd            = '0;
        // no request word is taken while reset is held
        s_tready       = (state_reg == spme_pkg::ST_IDLE) && aresetn;
        started_eff    = started_reg && !restart;
        exhausted_eff  = exhausted_reg && !restart;

        case (state_reg)
            spme_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (!started_eff) begin
                        // first request: start mask, first_offset + 1 steps
                        started_next   = 1'b1;
                        use_start_next = 1'b1;
                        cnt_next       = spme_pkg::STEP_W'(first_offset)
                                         + spme_pkg::STEP_W'(1);
                        exhausted_next = sts.no_usable;
                        zero_next      = sts.no_usable;
                        state_next     = sts.no_usable ? spme_pkg::ST_STORE
                                                       : spme_pkg::ST_LOAD;
                    end else begin
                        use_start_next = 1'b0;
                        cnt_next       = stride;
                        exhausted_next = exhausted_eff;
                        zero_next      = exhausted_eff;
                        state_next     = exhausted_eff ? spme_pkg::ST_STORE
                                                       : spme_pkg::ST_LOAD;
                    end
                end
            end
            spme_pkg::ST_LOAD: begin
                cmd.load      = 1'b1;
                cmd.use_start = use_start_reg;
                state_next    = spme_pkg::ST_COUNT;
            end
            spme_pkg::ST_COUNT: begin
                cmd.count  = 1'b1;
                state_next = spme_pkg::ST_SUM;
            end
            spme_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = spme_pkg::ST_CHECK;
            end
            spme_pkg::ST_CHECK: begin
                if (cnt_reg == '0 || sts.x_zero) begin
                    state_next = spme_pkg::ST_STORE;
                end else begin
                    state_next = spme_pkg::ST_RIPPLE;
                end
            end
            spme_pkg::ST_RIPPLE: begin
                cmd.ripple = 1'b1;
                state_next = spme_pkg::ST_FILL;
            end
            spme_pkg::ST_FILL: begin
                cmd.fill   = 1'b1;
                state_next = spme_pkg::ST_ADVANCE;
            end
            spme_pkg::ST_ADVANCE: begin
                cmd.advance = 1'b1;
                cnt_next    = cnt_reg - spme_pkg::STEP_W'(1);
                state_next  = spme_pkg::ST_CHECK;
            end
            spme_pkg::ST_STORE: begin
                if (out_free) begin
                    cmd.store      = 1'b1;
                    cmd.zero       = result_zero;
                    m_tvalid_next  = 1'b1;
                    done_next      = result_zero;
                    exhausted_next = result_zero;
                    state_next     = spme_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spme_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_done   = done_reg;

endmodule

// ----- hw/rtl/spme_dp.sv -----
// ----------------------------------------------------------------------------
// spme_dp
// Datapath of the mask enumerator: working mask, set-bit count, the
// next-combination step split into ripple, fill and advance, and the result register.
// ----------------------------------------------------------------------------
module spme_dp #(
    parameter int MASK_WIDTH = 64
) (
    input  logic                            aclk,
    input  spme_pkg::dp_cmd_t               cmd,
    output spme_pkg::dp_sts_t               sts,
    input  logic [spme_pkg::SKIP_W-1:0]     skip_low_bits,
    input  logic [spme_pkg::MAXB_W-1:0]     max_mask_bits,
    output logic [MASK_WIDTH-1:0]           mask_out
);

    localparam int KW     = $clog2(MASK_WIDTH + 2);
    localparam int IDX_W  = $clog2(MASK_WIDTH);
    localparam int LANES  = (MASK_WIDTH + 7) / 8;
    localparam int PAD_W  = LANES * 8;
    localparam int CMP_W  = 8;

    logic [MASK_WIDTH-1:0]  x_reg, x_next;
    logic [MASK_WIDTH-1:0]  cur_reg;
    logic [MASK_WIDTH-1:0]  out_reg;
    logic [MASK_WIDTH-1:0]  ripple_reg;
    logic                   carry_reg;
    logic [MASK_WIDTH-1:0]  fill_reg;
    logic [IDX_W-1:0]       low_idx_reg;
    logic [KW-1:0]          k_reg, k_next;
    logic [3:0]             lane_reg [LANES];

    logic [MASK_WIDTH-1:0]  lowest;
    logic [MASK_WIDTH:0]    ripple_sum;
    logic [IDX_W-1:0]       low_idx;
    logic [PAD_W-1:0]       x_pad;
    logic [KW-1:0]          k_sum;
    logic [MASK_WIDTH-1:0]  nx;
    logic [MASK_WIDTH-1:0]  usable_ones;
    logic                   over;
    logic [KW-1:0]          n_bits;
    logic [KW-1:0]          usable_cnt;
    logic [MASK_WIDTH-1:0]  shifted;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

    function automatic logic [MASK_WIDTH-1:0] low_ones(input logic [KW-1:0] n);
        logic [MASK_WIDTH-1:0] r;
        if (int'(n) >= MASK_WIDTH) begin
            r = '1;
        end else begin
            r = (MASK_WIDTH'(1) << n) - MASK_WIDTH'(1);
        end
        return r;
    endfunction

    assign sts.x_zero    = (x_reg == '0);
    assign sts.no_usable = (int'(skip_low_bits) >= MASK_WIDTH);

    // lowest set bit and its position (one-hot to binary)
    assign lowest     = x_reg & (MASK_WIDTH'(0) - x_reg);
    assign ripple_sum = {1'b0, x_reg} + {1'b0, lowest};

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < MASK_WIDTH; i++) begin
            if (lowest[i]) begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    assign x_pad = PAD_W'(x_reg);

    always_comb begin
        k_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            k_sum = k_sum + KW'(lane_reg[l]);
        end
    end

    // overflow test of the candidate against the usable width
    assign nx          = ripple_reg | fill_reg;
    assign usable_ones = {MASK_WIDTH{1'b1}} >> skip_low_bits;
    assign over        = carry_reg || ((nx & ~usable_ones) != '0);
    assign n_bits      = k_reg + KW'(1);
    assign usable_cnt  = KW'(MASK_WIDTH) - KW'(skip_low_bits);
    assign shifted     = x_reg << skip_low_bits;

    always_comb begin
        x_next = x_reg;
        k_next = k_reg;
        if (cmd.load) begin
            x_next = cmd.use_start ? MASK_WIDTH'(1) : (cur_reg >> skip_low_bits);
        end else if (cmd.sum) begin
            k_next = k_sum;
        end else if (cmd.advance) begin
            if (over) begin
                // restart one set bit wider, or end
                if (CMP_W'(n_bits) > CMP_W'(max_mask_bits) || n_bits > usable_cnt) begin
                    x_next = '0;
                end else begin
                    x_next = low_ones(n_bits);
                    k_next = n_bits;
                end
            end else begin
                x_next = nx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        k_reg <= k_next;
        if (cmd.count) begin
            for (int l = 0; l < LANES; l++) begin
                lane_reg[l] <= pop8(x_pad[l*8 +: 8]);
            end
        end
        if (cmd.ripple) begin
            ripple_reg  <= ripple_sum[MASK_WIDTH-1:0];
            carry_reg   <= ripple_sum[MASK_WIDTH];
            low_idx_reg <= low_idx;
        end
        if (cmd.fill) begin
            // run length minus one, moved down to bit zero
            fill_reg <= ((x_reg ^ ripple_reg) >> 2) >> low_idx_reg;
        end
        if (cmd.store) begin
            cur_reg <= cmd.zero ? '0 : shifted;
            out_reg <= cmd.zero ? '0 : shifted;
        end
    end

    assign mask_out = out_reg;

endmodule

// ----- hw/rtl/same_popcount_mask_enumerator.sv -----
// Sequence: an accepted request word runs load, count, sum and check, then
// ripple, fill, advance and check once per step, then store; steps is
// first_offset+1 on the first request and stride afterwards, cut short once
// the enumeration ends; a request that finds it ended goes straight to store.
// Throughput: one request at a time; its steps run one after another on the
// shared step unit. The result register frees the input side meanwhile.
// Reset (aresetn low, synchronous): registers to 6/8/1/0, enumeration not started.
// same_popcount_mask_enumerator
// Walks bit masks above a number of skipped low bits in increasing order within
// each set-bit count, then one set bit wider up to max_mask_bits, one mask per
// request word.
module same_popcount_mask_enumerator #(
    parameter int MASK_WIDTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spme_pkg::IN_TDATA_W-1:0]     s_tdata,    // [0] restart
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((MASK_WIDTH+7)/8)*8-1:0]     m_tdata,    // mask
    output logic                                m_tuser,    // [0] done_res
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spme_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TDATA_W = ((MASK_WIDTH + 7) / 8) * 8;

    logic [spme_pkg::SKIP_W-1:0]    skip_reg;
    logic [spme_pkg::MAXB_W-1:0]    maxb_reg;
    logic [spme_pkg::STRIDE_W-1:0]  stride_reg;
    logic [spme_pkg::OFFS_W-1:0]    offs_reg;
    spme_pkg::dp_cmd_t              cmd;
    spme_pkg::dp_sts_t              sts;
    logic [MASK_WIDTH-1:0]          mask_out;

    // register writes are dropped while reset is held
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg   <= spme_pkg::SKIP_RST;
            maxb_reg   <= spme_pkg::MAXB_RST;
            stride_reg <= spme_pkg::STRIDE_RST;
            offs_reg   <= spme_pkg::OFFS_RST;
        end else if (cfg_valid) begin
            case (spme_pkg::cfg_reg_t'(cfg_index))
                spme_pkg::REG_SKIP_LOW_BITS: begin
                    skip_reg <= cfg_data[spme_pkg::SKIP_W-1:0];
                end
                spme_pkg::REG_MAX_MASK_BITS: begin
                    maxb_reg <= cfg_data[spme_pkg::MAXB_W-1:0];
                end
                spme_pkg::REG_STRIDE: begin
                    stride_reg <= cfg_data;
                end
                spme_pkg::REG_FIRST_OFFSET: begin
                    offs_reg <= cfg_data[spme_pkg::OFFS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    spme_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .restart      (s_tdata[0]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_done       (m_tuser),
        .first_offset (offs_reg),
        .stride       (stride_reg),
        .cmd          (cmd),
        .sts          (sts)
    );

    spme_dp #(
        .MASK_WIDTH (MASK_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .cmd           (cmd),
        .sts           (sts),
        .skip_low_bits (skip_reg),
        .max_mask_bits (maxb_reg),
        .mask_out      (mask_out)
    );

    assign m_tdata = TDATA_W'(mask_out);

endmodule

// ----- hw/rtl/spme_checker.sv -----
// ----------------------------------------------------------------------------
// spme_checker
// Port-level checks of the mask enumerator, bound to the top level.
// ----------------------------------------------------------------------------
`include "same_popcount_mask_enumerator_macros.svh"

module spme_checker #(
    parameter int MASK_WIDTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [((MASK_WIDTH+7)/8)*8-1:0]     m_tdata,
    input  logic                                m_tuser
);

    // done word carries an empty mask
    `SPME_ASSERT_IMP(a_done_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0, "done with nonzero mask")

    // a live mask is never empty
    `SPME_ASSERT_IMP(a_live_nonzero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata != '0, "empty mask without done")

    // one request in flight at a time
    `SPME_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // stalled result word holds
    `SPME_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind same_popcount_mask_enumerator spme_checker #(
    .MASK_WIDTH (MASK_WIDTH)
) u_spme_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives request words into the same-popcount mask enumerator with random
// idle gaps on both stream sides and checks every mask word against a
// behavioral predictor or a typed table row. A directed table with register
// changes comes first, then random phases of settings and requests.
// ----------------------------------------------------------------------------
module testbench;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ,
        ROW_REQ_MASK,
        ROW_REQ_DONE
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        spme_pkg::cfg_reg_t reg_sel;
        int unsigned        value;
        bit                 restart;
        bit [63:0]          mask;
    } plan_row_t;

    typedef struct {
        bit [63:0] mask;
        bit        done;
    } mask_word_t;

    localparam int DIR_ROWS    = 36;
    localparam int RANDOM_REQS = 950;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [63:0]        m_tdata;
    logic               m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    spme_pkg::cfg_reg_t cfg_index = spme_pkg::REG_SKIP_LOW_BITS;
    logic [6:0]         cfg_data  = '0;

    // predictor copy of the registers and the walk
    int unsigned reg_skip   = spme_pkg::SKIP_RST;
    int unsigned reg_maxb   = spme_pkg::MAXB_RST;
    int unsigned reg_stride = spme_pkg::STRIDE_RST;
    int unsigned reg_offset = spme_pkg::OFFS_RST;
    bit [63:0]   walk_mask  = 64'd1 << spme_pkg::SKIP_RST;
    bit          walk_started   = 1'b0;
    bit          walk_exhausted = 1'b0;

    mask_word_t  pending_masks[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;

    plan_row_t directed_plan [DIR_ROWS] = '{
        '{ROW_REQ_MASK, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h80},
        '{ROW_REQ_MASK, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h100},
        '{ROW_REQ_MASK, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b1, 64'h80},
        // no skipped bits: the single bit walks up into the carry out of bit 63
        '{ROW_CFG,      spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_MAX_MASK_BITS, 2, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_FIRST_OFFSET, 62, 1'b0, 64'h0},
        '{ROW_REQ_MASK, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b1, 64'h8000_0000_0000_0000},
        '{ROW_REQ_MASK, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h3},
        '{ROW_REQ,      spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_MAX_MASK_BITS, 1, 1'b0, 64'h0},
        '{ROW_REQ_MASK, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b1, 64'h8000_0000_0000_0000},
        '{ROW_REQ_DONE, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h0},
        '{ROW_REQ_DONE, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h0},
        '{ROW_REQ_MASK, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b1, 64'h8000_0000_0000_0000},
        // zero stride repeats the mask
        '{ROW_CFG,      spme_pkg::REG_STRIDE,        0, 1'b0, 64'h0},
        '{ROW_REQ_MASK, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h8000_0000_0000_0000},
        // zero max bits ends the walk at the first width change
        '{ROW_CFG,      spme_pkg::REG_SKIP_LOW_BITS, 32, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_MAX_MASK_BITS, 0, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_FIRST_OFFSET, 31, 1'b0, 64'h0},
        '{ROW_REQ_DONE, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b1, 64'h0},
        '{ROW_REQ_DONE, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h0},
        // one usable bit: next width does not fit
        '{ROW_CFG,      spme_pkg::REG_SKIP_LOW_BITS, 63, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_MAX_MASK_BITS, 2, 1'b0, 64'h0},
        '{ROW_REQ_DONE, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b1, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_SKIP_LOW_BITS, 1, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_MAX_MASK_BITS, 31, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_STRIDE,        64, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_FIRST_OFFSET,  63, 1'b0, 64'h0},
        '{ROW_REQ,      spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b1, 64'h0},
        '{ROW_REQ,      spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h0},
        '{ROW_REQ,      spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_STRIDE,        1, 1'b0, 64'h0},
        '{ROW_CFG,      spme_pkg::REG_FIRST_OFFSET,  0, 1'b0, 64'h0},
        '{ROW_REQ_MASK, spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b1, 64'h4},
        '{ROW_REQ,      spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h0},
        '{ROW_REQ,      spme_pkg::REG_SKIP_LOW_BITS, 0, 1'b0, 64'h0}
    };

    same_popcount_mask_enumerator #(
        .MASK_WIDTH(64)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic bit [63:0] low_run(int unsigned n);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // one next-combination step on an unshifted mask, 0 when the walk ends
    function automatic bit [63:0] next_combination(bit [63:0] x, int unsigned usable);
        bit [63:0]   lowest;
        bit [63:0]   ripple;
        bit [63:0]   nx;
        int unsigned k;
        bit          over;
        if (x == 0)
            return 64'd0;
        k      = $countones(x);
        lowest = x & (~x + 64'd1);
        ripple = x + lowest;
        nx     = 64'd0;
        if (ripple == 0) begin
            over = 1'b1;
        end else begin
            nx   = ripple | low_run(k - $countones(ripple));
            over = (usable < 64) && ((nx >> usable) != 0);
        end
        if (over) begin
            if (k + 1 > reg_maxb || k + 1 > usable)
                return 64'd0;
            nx = low_run(k + 1);
        end
        return nx;
    endfunction

    function automatic mask_word_t predict_mask(bit restart);
        mask_word_t  word;
        int unsigned steps;
        int unsigned usable;
        bit [63:0]   x;
        if (restart) begin
            walk_started   = 1'b0;
            walk_exhausted = 1'b0;
        end
        if (!walk_started) begin
            walk_mask      = 64'd1 << reg_skip;
            walk_exhausted = (walk_mask == 0);
            steps          = reg_offset + 1;
            walk_started   = 1'b1;
        end else begin
            steps = reg_stride;
        end
        if (!walk_exhausted) begin
            usable = 64 - reg_skip;
            x      = walk_mask >> reg_skip;
            for (int unsigned i = 0; i < steps && x != 0; i++)
                x = next_combination(x, usable);
            walk_mask = x << reg_skip;
            if (walk_mask == 0)
                walk_exhausted = 1'b1;
        end
        if (walk_exhausted) begin
            walk_mask = 64'd0;
            word.mask = 64'd0;
            word.done = 1'b1;
        end else begin
            word.mask = walk_mask;
            word.done = 1'b0;
        end
        return word;
    endfunction

    function automatic int unsigned idle_cycles();
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                               int unsigned typical);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, typical);
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // hold off requests until every mask word is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_masks.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(spme_pkg::cfg_reg_t sel, int unsigned value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value[6:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (sel)
            spme_pkg::REG_SKIP_LOW_BITS: reg_skip   = value & 32'h3F;
            spme_pkg::REG_MAX_MASK_BITS: reg_maxb   = value & 32'h1F;
            spme_pkg::REG_STRIDE:        reg_stride = value & 32'h7F;
            spme_pkg::REG_FIRST_OFFSET:  reg_offset = value & 32'h3F;
            default: ;
        endcase
    endtask

    task automatic send_request(bit restart, row_kind_t kind, bit [63:0] typed_mask);
        int unsigned gap;
        mask_word_t  word;
        gap = idle_cycles();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge aclk); while (!s_tready);
        word = predict_mask(restart);
        case (kind)
            ROW_REQ_MASK: begin
                word.mask = typed_mask;
                word.done = 1'b0;
            end
            ROW_REQ_DONE: begin
                word.mask = 64'd0;
                word.done = 1'b1;
            end
            default: ;
        endcase
        pending_masks.insert(pending_masks.size(), word);
    endtask

    // result side: random stalls, every accepted word checked in order
    always @(posedge aclk) begin
        int unsigned rx_wait;
        mask_word_t  want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = idle_cycles();
        end else if (m_tready) begin
            if (m_tvalid) begin
                if (pending_masks.size() == 0) begin
                    report_mismatch($sformatf("mask word %h with nothing pending", m_tdata));
                end else begin
                    want = pending_masks.pop_front();
                    if (m_tdata !== want.mask)
                        report_mismatch($sformatf("mask %h, wanted %h", m_tdata, want.mask));
                    if (m_tuser !== want.done)
                        report_mismatch($sformatf("done %b, wanted %b", m_tuser, want.done));
                end
                rx_wait = idle_cycles();
                if (rx_wait != 0) begin
                    m_tready <= 1'b0;
                    rx_wait--;
                end
            end
        end else if (rx_wait == 0) begin
            m_tready <= 1'b1;
        end else begin
            rx_wait--;
        end
    end

    initial begin
        int unsigned sent;
        int unsigned run_len;
        bit          restart;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG)
                write_register(directed_plan[i].reg_sel, directed_plan[i].value);
            else
                send_request(directed_plan[i].restart, directed_plan[i].kind,
                             directed_plan[i].mask);
        end

        sent = 0;
        while (sent < RANDOM_REQS) begin
            // small max bit counts so walks reach the end often
            write_register(spme_pkg::REG_SKIP_LOW_BITS, pick_value(1, 32, 32));
            write_register(spme_pkg::REG_MAX_MASK_BITS, pick_value(1, 31, 4));
            write_register(spme_pkg::REG_STRIDE,        pick_value(1, 64, 12));
            write_register(spme_pkg::REG_FIRST_OFFSET,  pick_value(0, 63, 15));
            quiet   = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(20, 60);
            for (int unsigned i = 0; i < run_len; i++) begin
                // a phase may carry on the walk left by the previous settings
                if (i == 0)
                    restart = $urandom_range(0, 1);
                else
                    restart = ($urandom_range(0, 19) == 0);
                if ($urandom_range(0, 39) == 0)
                    wait_idle();
                send_request(restart, ROW_REQ, 64'd0);
                sent++;
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
